@@ rtl/fsp_pkg.sv @@
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and character constants for the conversion specification parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

    typedef enum logic [1:0] {
        PH_FLAGS = 2'd0,
        PH_WIDTH = 2'd1,
        PH_PREC  = 2'd2,
        PH_LEN   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_KNOWN   = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_END     = 2'd2
    } status_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } type_hit_t;

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_SHARP = 8'h23;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_H     = 8'h68;
    localparam logic [7:0]  CH_L     = 8'h6C;
    localparam logic [7:0]  CH_J     = 8'h6A;
    localparam logic [7:0]  CH_Z     = 8'h7A;

    localparam logic [15:0] SAT_MAX  = 16'hFFFF;

    localparam logic [4:0] FLAG_PLUS  = 5'b00001;
    localparam logic [4:0] FLAG_MINUS = 5'b00010;
    localparam logic [4:0] FLAG_SHARP = 5'b00100;
    localparam logic [4:0] FLAG_SPACE = 5'b01000;
    localparam logic [4:0] FLAG_ZERO  = 5'b10000;

    localparam logic [5:0] LEN_H  = 6'b000001;
    localparam logic [5:0] LEN_HH = 6'b000010;
    localparam logic [5:0] LEN_L  = 6'b000100;
    localparam logic [5:0] LEN_LL = 6'b001000;
    localparam logic [5:0] LEN_J  = 6'b010000;
    localparam logic [5:0] LEN_Z  = 6'b100000;

    // "sSpdDioOuUxXcCn%"
    localparam logic [7:0] TYPE_TABLE [16] = '{
        8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6F, 8'h4F,
        8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43, 8'h6E, 8'h25
    };

    function automatic type_hit_t type_lookup(input logic [7:0] c);
        type_hit_t r;
        r = '0;
        for (int i = 15; i >= 0; i--) begin
            if (TYPE_TABLE[i] == c) begin
                r.hit = 1'b1;
                r.idx = 4'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] flag_of(input logic [7:0] c);
        logic [4:0] f;
        case (c)
            CH_PLUS:  f = FLAG_PLUS;
            CH_MINUS: f = FLAG_MINUS;
            CH_SHARP: f = FLAG_SHARP;
            CH_SPACE: f = FLAG_SPACE;
            CH_ZERO:  f = FLAG_ZERO;
            default:  f = 5'b00000;
        endcase
        return f;
    endfunction

    function automatic logic [15:0] sat_acc(input logic [15:0] acc, input logic [7:0] c);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, 4'(c - CH_ZERO)};
        return (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[15:0];
    endfunction

endpackage

@@ rtl/format_spec_parser_core.sv @@
// ----------------------------------------------------------------------------
// format_spec_parser_core
// Parses the bytes after a percent sign into one conversion specification.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and sustains one word per clock, but for the stall
// named below. A byte passes an input register, then a single update of the
// phase and accumulator state; a terminating byte (table type, unexpected
// byte or NUL) loads the result register and clears the state for the next
// specification. The input stage stalls only when a result is due and the
// result register is still held by a stalled consumer.
module format_spec_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  type_code,
    output logic [7:0]  bad_char,
    output logic [4:0]  flag_bits,
    output logic [15:0] field_width,
    output logic        dot_seen,
    output logic        precision_given,
    output logic [15:0] precision_value,
    output logic [5:0]  length_bits
);
    import fsp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  ch_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  flags_reg, flags_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] prec_reg, prec_next;
    logic        dot_reg, dot_next;
    logic        pdig_reg, pdig_next;
    logic [5:0]  len_reg, len_next;
    logic        last_h_reg, last_h_next;
    logic        last_l_reg, last_l_next;

    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  bad_reg, bad_next;
    logic [4:0]  oflags_reg;
    logic [15:0] owidth_reg;
    logic        odot_reg;
    logic        opdig_reg;
    logic [15:0] oprec_reg;
    logic [5:0]  olen_reg, olen_final;

    logic        is_digit, is_len, term, advance, out_free;
    logic [4:0]  fbit;
    logic [5:0]  len_take;
    type_hit_t   th;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_len   = (ch_reg == CH_H) || (ch_reg == CH_L) || (ch_reg == CH_J)
                   || (ch_reg == CH_Z);
    assign fbit     = flag_of(ch_reg);
    assign th       = type_lookup(ch_reg);

    always_comb
    begin
        len_take = len_reg;
        if (last_h_reg)
            len_take = len_take | ((ch_reg == CH_H) ? LEN_HH : LEN_H);
        if (last_l_reg)
            len_take = len_take | ((ch_reg == CH_L) ? LEN_LL : LEN_L);
        if (ch_reg == CH_J)
            len_take = len_take | LEN_J;
        if (ch_reg == CH_Z)
            len_take = len_take | LEN_Z;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        flags_next  = flags_reg;
        width_next  = width_reg;
        prec_next   = prec_reg;
        dot_next    = dot_reg;
        pdig_next   = pdig_reg;
        len_next    = len_reg;
        last_h_next = last_h_reg;
        last_l_next = last_l_reg;
        term        = 1'b0;
        case (phase_reg)
            PH_WIDTH:
            begin
                if (is_digit)
                    width_next = sat_acc(width_reg, ch_reg);
                else if (ch_reg == CH_DOT)
                begin
                    dot_next   = 1'b1;
                    phase_next = PH_PREC;
                end
                else if (!is_len)
                    term = 1'b1;
            end
            PH_PREC:
            begin
                if (is_digit)
                begin
                    prec_next = sat_acc(prec_reg, ch_reg);
                    pdig_next = 1'b1;
                end
                else if (!is_len)
                    term = 1'b1;
            end
            PH_LEN:
            begin
                if (!is_len)
                    term = 1'b1;
            end
            default:
            begin
                if (fbit != 5'b00000)
                    flags_next = flags_reg | fbit;
                else if (is_digit)
                begin
                    width_next = sat_acc(16'd0, ch_reg);
                    phase_next = PH_WIDTH;
                end
                else if (ch_reg == CH_DOT)
                begin
                    dot_next   = 1'b1;
                    phase_next = PH_PREC;
                end
                else if (!is_len)
                    term = 1'b1;
            end
        endcase

        if (is_len && !term && !(phase_reg == PH_WIDTH && is_digit)
            && !(phase_reg == PH_PREC && is_digit)
            && !((phase_reg == PH_FLAGS) && (fbit != 5'b00000)))
        begin
            len_next    = len_take;
            last_h_next = (ch_reg == CH_H);
            last_l_next = (ch_reg == CH_L);
            phase_next  = PH_LEN;
        end

        if (term)
        begin
            phase_next  = PH_FLAGS;
            flags_next  = '0;
            width_next  = '0;
            prec_next   = '0;
            dot_next    = 1'b0;
            pdig_next   = 1'b0;
            len_next    = '0;
            last_h_next = 1'b0;
            last_l_next = 1'b0;
        end
    end

    always_comb
    begin
        olen_final = len_reg | (last_h_reg ? LEN_H : 6'd0) | (last_l_reg ? LEN_L : 6'd0);
        status_next = ST_UNKNOWN;
        type_next   = 4'd0;
        bad_next    = ch_reg;
        if (ch_reg == CH_NUL)
        begin
            status_next = ST_END;
            bad_next    = 8'd0;
        end
        else if (th.hit)
        begin
            status_next = ST_KNOWN;
            type_next   = th.idx;
            bad_next    = 8'd0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!term || out_free);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_FLAGS;
            flags_reg     <= '0;
            width_reg     <= '0;
            prec_reg      <= '0;
            dot_reg       <= 1'b0;
            pdig_reg      <= 1'b0;
            len_reg       <= '0;
            last_h_reg    <= 1'b0;
            last_l_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                phase_reg  <= phase_next;
                flags_reg  <= flags_next;
                width_reg  <= width_next;
                prec_reg   <= prec_next;
                dot_reg    <= dot_next;
                pdig_reg   <= pdig_next;
                len_reg    <= len_next;
                last_h_reg <= last_h_next;
                last_l_reg <= last_l_next;
            end
            if (advance && term)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            ch_reg <= ch;
        if (advance && term)
        begin
            status_reg <= status_next;
            type_reg   <= type_next;
            bad_reg    <= bad_next;
            oflags_reg <= flags_reg;
            owidth_reg <= width_reg;
            odot_reg   <= dot_reg;
            opdig_reg  <= pdig_reg;
            oprec_reg  <= prec_reg;
            olen_reg   <= olen_final;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign type_code       = type_reg;
    assign bad_char        = bad_reg;
    assign flag_bits       = oflags_reg;
    assign field_width     = owidth_reg;
    assign dot_seen        = odot_reg;
    assign precision_given = opdig_reg;
    assign precision_value = oprec_reg;
    assign length_bits     = olen_reg;

endmodule

@@ verif/format_spec_checker.sv @@
// ----------------------------------------------------------------------------
// format_spec_checker
// Watches both channels of the conversion specification parser. Each
// accepted byte runs through a local parser model; every terminating byte
// queues one expected specification. Each accepted result is compared with
// the oldest queued specification, and failures are counted for the top.
// ----------------------------------------------------------------------------
module format_spec_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [3:0]  type_code,
    input  logic [7:0]  bad_char,
    input  logic [4:0]  flag_bits,
    input  logic [15:0] field_width,
    input  logic        dot_seen,
    input  logic        precision_given,
    input  logic [15:0] precision_value,
    input  logic [5:0]  length_bits,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [3:0]  type_code;
        logic [7:0]  bad_char;
        logic [4:0]  flag_bits;
        logic [15:0] field_width;
        logic        dot_seen;
        logic        precision_given;
        logic [15:0] precision_value;
        logic [5:0]  length_bits;
    } spec_result_t;

    spec_result_t expected_specs [$];

    phase_t      parse_phase;
    logic [4:0]  flags_acc;
    logic [15:0] width_val;
    logic [15:0] prec_val;
    logic        dot_hit;
    logic        prec_hit;
    logic [5:0]  len_acc;
    logic        pend_h;
    logic        pend_l;

    function automatic void clear_spec();
        parse_phase = PH_FLAGS;
        flags_acc   = '0;
        width_val   = '0;
        prec_val    = '0;
        dot_hit     = 1'b0;
        prec_hit    = 1'b0;
        len_acc     = '0;
        pend_h      = 1'b0;
        pend_l      = 1'b0;
    endfunction

    function automatic logic [15:0] add_decimal(input logic [15:0] acc, input logic [7:0] c);
        int unsigned v;
        v = 32'(acc) * 32'd10 + 32'(c) - 32'(CH_ZERO);
        return (v > 32'(SAT_MAX)) ? SAT_MAX : 16'(v);
    endfunction

    function automatic logic [4:0] flag_mask(input logic [7:0] c);
        logic [4:0] m;
        m = '0;
        if (c == CH_PLUS)  m = FLAG_PLUS;
        if (c == CH_MINUS) m = FLAG_MINUS;
        if (c == CH_SHARP) m = FLAG_SHARP;
        if (c == CH_SPACE) m = FLAG_SPACE;
        if (c == CH_ZERO)  m = FLAG_ZERO;
        return m;
    endfunction

    function automatic void note_length(input logic [7:0] c);
        if (pend_h) len_acc |= (c == CH_H) ? LEN_HH : LEN_H;
        if (pend_l) len_acc |= (c == CH_L) ? LEN_LL : LEN_L;
        if (c == CH_J) len_acc |= LEN_J;
        if (c == CH_Z) len_acc |= LEN_Z;
        pend_h      = (c == CH_H);
        pend_l      = (c == CH_L);
        parse_phase = PH_LEN;
    endfunction

    // Return 1 when c closes the specification, with the finished spec in r.
    function automatic bit parse_char(input logic [7:0] c, output spec_result_t r);
        logic [4:0] fm;
        bit         digit;
        bit         len_char;
        fm       = flag_mask(c);
        digit    = (c >= CH_ZERO) && (c <= CH_NINE);
        len_char = (c == CH_H) || (c == CH_L) || (c == CH_J) || (c == CH_Z);
        r        = '0;
        case (parse_phase)
            PH_WIDTH:
            begin
                if (digit) begin
                    width_val = add_decimal(width_val, c);
                    return 1'b0;
                end
                if (c == CH_DOT) begin
                    dot_hit     = 1'b1;
                    parse_phase = PH_PREC;
                    return 1'b0;
                end
                if (len_char) begin
                    note_length(c);
                    return 1'b0;
                end
            end
            PH_PREC:
            begin
                if (digit) begin
                    prec_val = add_decimal(prec_val, c);
                    prec_hit = 1'b1;
                    return 1'b0;
                end
                if (len_char) begin
                    note_length(c);
                    return 1'b0;
                end
            end
            PH_LEN:
            begin
                if (len_char) begin
                    note_length(c);
                    return 1'b0;
                end
            end
            default:
            begin
                if (fm != '0) begin
                    flags_acc |= fm;
                    return 1'b0;
                end
                if (digit) begin
                    width_val   = add_decimal('0, c);
                    parse_phase = PH_WIDTH;
                    return 1'b0;
                end
                if (c == CH_DOT) begin
                    dot_hit     = 1'b1;
                    parse_phase = PH_PREC;
                    return 1'b0;
                end
                if (len_char) begin
                    note_length(c);
                    return 1'b0;
                end
            end
        endcase

        // close a pending single h or l
        if (pend_h) len_acc |= LEN_H;
        if (pend_l) len_acc |= LEN_L;

        r.status   = ST_UNKNOWN;
        r.bad_char = c;
        if (c == CH_NUL) begin
            r.status   = ST_END;
            r.bad_char = '0;
        end else begin
            for (int i = 0; i < 16; i++) begin
                if (TYPE_TABLE[i] == c) begin
                    r.status    = ST_KNOWN;
                    r.type_code = 4'(i);
                    r.bad_char  = '0;
                end
            end
        end
        r.flag_bits       = flags_acc;
        r.field_width     = width_val;
        r.dot_seen        = dot_hit;
        r.precision_given = prec_hit;
        r.precision_value = prec_val;
        r.length_bits     = len_acc;
        clear_spec();
        return 1'b1;
    endfunction

    function automatic string spec_text(input spec_result_t s);
        return $sformatf({"status=%0d type=%0d bad=%02h flags=%02h width=%0d ",
                          "dot=%0d pgiven=%0d prec=%0d len=%02h"},
                         s.status, s.type_code, s.bad_char, s.flag_bits, s.field_width,
                         s.dot_seen, s.precision_given, s.precision_value, s.length_bits);
    endfunction

    always @(posedge clk) begin
        spec_result_t want;
        spec_result_t got;
        bit           closed;
        if (!rst_n) begin
            clear_spec();
            expected_specs.delete();
        end else begin
            if (out_valid && out_ready) begin
                got.status          = status_t'(status);
                got.type_code       = type_code;
                got.bad_char        = bad_char;
                got.flag_bits       = flag_bits;
                got.field_width     = field_width;
                got.dot_seen        = dot_seen;
                got.precision_given = precision_given;
                got.precision_value = precision_value;
                got.length_bits     = length_bits;
                if (expected_specs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected spec word: %s", spec_text(got));
                end else begin
                    want = expected_specs.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("spec mismatch, expected: %s", spec_text(want));
                            $display("spec mismatch, actual:   %s", spec_text(got));
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                closed = parse_char(ch, want);
                if (closed)
                    expected_specs.push_back(want);
            end
        end
        pending <= expected_specs.size();
    end

endmodule

@@ verif/format_spec_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// format_spec_parser_core_tb
// Feeds format bytes to the conversion specification parser: a short
// directed string with every flag, saturated width, zero-led precision,
// doubled length modifiers, NUL, a high byte and an out-of-order digit,
// then random well-formed and broken specifications, mostly under random stalls.
// ----------------------------------------------------------------------------
module format_spec_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsp_pkg::*;

    localparam logic [7:0] FLAG_CHARS [5] = '{CH_PLUS, CH_MINUS, CH_SHARP, CH_SPACE, CH_ZERO};
    localparam logic [7:0] LEN_CHARS [4]  = '{CH_H, CH_L, CH_J, CH_Z};
    localparam logic [7:0] STRAY_CHARS [6] = '{CH_PLUS, CH_SHARP, CH_SPACE, CH_DOT, CH_ZERO, CH_H};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  ch        = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  type_code;
    logic [7:0]  bad_char;
    logic [4:0]  flag_bits;
    logic [15:0] field_width;
    logic        dot_seen;
    logic        precision_given;
    logic [15:0] precision_value;
    logic [5:0]  length_bits;

    int          fail_count;
    int          pending;
    bit          idle_en    = 1'b0;
    int          bytes_sent = 0;
    int          spec_count = 0;
    logic [3:0]  type_rr    = '0;

    always #5 clk = ~clk;

    format_spec_parser_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .ch              (ch),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .type_code       (type_code),
        .bad_char        (bad_char),
        .flag_bits       (flag_bits),
        .field_width     (field_width),
        .dot_seen        (dot_seen),
        .precision_given (precision_given),
        .precision_value (precision_value),
        .length_bits     (length_bits)
    );

    format_spec_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .ch              (ch),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .type_code       (type_code),
        .bad_char        (bad_char),
        .flag_bits       (flag_bits),
        .field_width     (field_width),
        .dot_seen        (dot_seen),
        .precision_given (precision_given),
        .precision_value (precision_value),
        .length_bits     (length_bits),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    task automatic send_byte(input logic [7:0] c);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Hold input until every queued spec has come back.
    task automatic await_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random_spec();
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) send_byte(FLAG_CHARS[$urandom_range(0, 4)]);
        if ($urandom_range(0, 1) == 1) begin
            send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
            send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3));
        end
        if ($urandom_range(0, 4) < 2) begin
            send_byte(CH_DOT);
            send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
        end
        if ($urandom_range(0, 4) < 2) begin
            pick = $urandom_range(0, 6);
            case (pick)
                0: send_byte(CH_H);
                1: send_text("hh");
                2: send_byte(CH_L);
                3: send_text("ll");
                4: send_byte(CH_J);
                5: send_byte(CH_Z);
                default: repeat ($urandom_range(1, 3)) send_byte(LEN_CHARS[$urandom_range(0, 3)]);
            endcase
        end
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
            send_byte(TYPE_TABLE[type_rr]);
            type_rr++;
        end else if (pick < 17) begin
            send_byte(CH_NUL);
        end else if (pick < 19) begin
            send_byte(STRAY_CHARS[$urandom_range(0, 5)]);
        end else begin
            send_byte(8'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n   <= 1'b1;
        idle_en = 1'b1;

        send_text("#0+- 70000.0012hhx");
        send_text("ll");
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_text("h5");
        await_results();

        while (bytes_sent < 550) begin
            idle_en = (bytes_sent < 470) && (spec_count % 24 < 16);
            send_random_spec();
            spec_count++;
            if (spec_count == 40)
                await_results();
        end

        await_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ format_spec_parser_core.f @@
rtl/fsp_pkg.sv
rtl/format_spec_parser_core.sv
verif/format_spec_checker.sv
verif/format_spec_parser_core_tb.sv
